// ===== sv/kdar_pkg.sv =====
// Shared types and constants for the key debounce / auto-repeat scanner.
// No dependencies; every other file in this folder uses it.
`default_nettype none

package kdar_pkg;

    // Command codes on the input channel
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_PEEK     = 3'd1;
    localparam logic [2:0] CMD_READ_CLR = 3'd2;
    localparam logic [2:0] CMD_HELD     = 3'd3;
    localparam logic [2:0] CMD_BEEP     = 3'd4;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] REG_REPEAT_DELAY = 3'd1;
    localparam logic [2:0] REG_REPEAT_PER   = 3'd2;
    localparam logic [2:0] REG_REPEAT_MASK  = 3'd3;
    localparam logic [2:0] REG_VALID_MASK   = 3'd4;

    localparam logic [15:0] RST_DEBOUNCE     = 16'd10;
    localparam logic [15:0] RST_REPEAT_DELAY = 16'd300;
    localparam logic [15:0] RST_REPEAT_PER   = 16'd100;
    localparam logic [15:0] RST_REPEAT_MASK  = 16'h0000;
    localparam logic [15:0] RST_VALID_MASK   = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_PEEK,
        OP_READ_CLR,
        OP_HELD,
        OP_BEEP
    } t_op;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] key_levels_n;
        logic [15:0] key_select;
        logic [15:0] beep_ms;
        logic [7:0]  beep_level;
    } t_in_item;

    typedef struct packed {
        logic [15:0] key_bits;
        logic [31:0] held_ticks;
        logic [31:0] tick_now;
        logic [7:0]  beep_volume_out;
    } t_out_item;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] repeat_delay_ms;
        logic [15:0] repeat_period_ms;
        logic [15:0] repeat_key_mask;
        logic [15:0] valid_key_mask;
    } t_cfg;

    // Classified command as it sits in the queue between front and back
    typedef struct packed {
        t_op         op;
        logic [15:0] keys;
        logic [15:0] sel;
        logic [15:0] beep_ms;
        logic [7:0]  beep_level;
    } t_cmd_entry;

endpackage

`default_nettype wire

// ===== sv/kdar_cfg.sv =====
// APB-style configuration registers for the key scanner.
// Depends on kdar_pkg.
`default_nettype none

module kdar_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output kdar_pkg::t_cfg     o_cfg
);

    kdar_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= kdar_pkg::RST_DEBOUNCE;
            r_cfg.repeat_delay_ms  <= kdar_pkg::RST_REPEAT_DELAY;
            r_cfg.repeat_period_ms <= kdar_pkg::RST_REPEAT_PER;
            r_cfg.repeat_key_mask  <= kdar_pkg::RST_REPEAT_MASK;
            r_cfg.valid_key_mask   <= kdar_pkg::RST_VALID_MASK;
        end else if (w_wr) begin
            unique case (w_idx)
                kdar_pkg::REG_DEBOUNCE:     r_cfg.debounce_ms      <= pwdata[15:0];
                kdar_pkg::REG_REPEAT_DELAY: r_cfg.repeat_delay_ms  <= pwdata[15:0];
                kdar_pkg::REG_REPEAT_PER:   r_cfg.repeat_period_ms <= pwdata[15:0];
                kdar_pkg::REG_REPEAT_MASK:  r_cfg.repeat_key_mask  <= pwdata[15:0];
                kdar_pkg::REG_VALID_MASK:   r_cfg.valid_key_mask   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            kdar_pkg::REG_DEBOUNCE:     prdata = {16'h0, r_cfg.debounce_ms};
            kdar_pkg::REG_REPEAT_DELAY: prdata = {16'h0, r_cfg.repeat_delay_ms};
            kdar_pkg::REG_REPEAT_PER:   prdata = {16'h0, r_cfg.repeat_period_ms};
            kdar_pkg::REG_REPEAT_MASK:  prdata = {16'h0, r_cfg.repeat_key_mask};
            kdar_pkg::REG_VALID_MASK:   prdata = {16'h0, r_cfg.valid_key_mask};
            default:                    prdata = 32'h0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/kdar_front.sv =====
// Front end: takes input transactions, decodes the command and masks the
// raw key lines. Depends on kdar_pkg.
`default_nettype none

module kdar_front #(
    parameter int NUM_KEYS = 16
) (
    input  wire logic                 push,
    output logic                      full,
    input  wire kdar_pkg::t_in_item   i_in_item,
    input  wire kdar_pkg::t_cfg       i_cfg,
    input  wire logic                 i_q_full,
    output logic                      o_q_wr,
    output kdar_pkg::t_cmd_entry      o_q_entry
);

    logic [15:0] w_line_mask;

    // Key lines that physically exist
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_line_mask[i] = (i < NUM_KEYS);
        end
    end

    assign full   = i_q_full;
    assign o_q_wr = push & ~i_q_full;

    always_comb begin
        o_q_entry.keys       = ~i_in_item.key_levels_n & i_cfg.valid_key_mask & w_line_mask;
        o_q_entry.sel        = i_in_item.key_select;
        o_q_entry.beep_ms    = i_in_item.beep_ms;
        o_q_entry.beep_level = i_in_item.beep_level;
        unique case (i_in_item.cmd)
            kdar_pkg::CMD_TICK:     o_q_entry.op = kdar_pkg::OP_TICK;
            kdar_pkg::CMD_PEEK:     o_q_entry.op = kdar_pkg::OP_PEEK;
            kdar_pkg::CMD_READ_CLR: o_q_entry.op = kdar_pkg::OP_READ_CLR;
            kdar_pkg::CMD_HELD:     o_q_entry.op = kdar_pkg::OP_HELD;
            kdar_pkg::CMD_BEEP:     o_q_entry.op = kdar_pkg::OP_BEEP;
            default:                o_q_entry.op = kdar_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/kdar_fifo.sv =====
// Two-entry command queue between front end and execution back end.
// Depends on kdar_pkg.
`default_nettype none

module kdar_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr,
    input  wire kdar_pkg::t_cmd_entry  i_wr_data,
    output logic                       o_full,
    input  wire logic                  i_rd,
    output logic                       o_empty,
    output kdar_pkg::t_cmd_entry       o_rd_data
);

    kdar_pkg::t_cmd_entry r_mem [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_count;
    logic                 w_do_wr;
    logic                 w_do_rd;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign w_do_wr   = i_wr & ~o_full;
    assign w_do_rd   = i_rd & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_do_wr) r_wr_ptr <= ~r_wr_ptr;
            if (w_do_rd) r_rd_ptr <= ~r_rd_ptr;
            case ({w_do_wr, w_do_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/kdar_back.sv =====
// Back end: holds scanner state, executes queued commands, runs the serial
// repeat-period remainder and drives the result register. Depends on kdar_pkg.
`default_nettype none

module kdar_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire kdar_pkg::t_cfg        i_cfg,
    input  wire logic                  i_q_empty,
    input  wire kdar_pkg::t_cmd_entry  i_q_data,
    output logic                       o_q_rd,
    output logic                       empty,
    input  wire logic                  pop,
    output kdar_pkg::t_out_item        o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

    t_state               r_state,     n_state;
    kdar_pkg::t_cmd_entry r_ent,       n_ent;
    logic [31:0]          r_tc,        n_tc;
    logic [31:0]          r_down_age,  n_down_age;   // tick - last_down_time
    logic [31:0]          r_held,      n_held;       // tick - last_change_time
    logic [15:0]          r_pressed,   n_pressed;
    logic [15:0]          r_down_set,  n_down_set;
    logic [15:0]          r_beep_rem,  n_beep_rem;
    logic [7:0]           r_beep_vol,  n_beep_vol;
    logic [15:0]          r_res_bits,  n_res_bits;
    logic [31:0]          r_res_held,  n_res_held;
    logic [15:0]          r_rep_keys,  n_rep_keys;
    logic [31:0]          r_dvd,       n_dvd;
    logic [15:0]          r_rem,       n_rem;
    logic [4:0]           r_cnt,       n_cnt;
    logic                 r_out_valid, n_out_valid;
    kdar_pkg::t_out_item  r_out,       n_out;

    logic [31:0] w_age1;
    logic [31:0] w_held_new;
    logic [15:0] w_period;
    logic [16:0] w_trial;
    logic [16:0] w_diff;

    assign empty      = ~r_out_valid;
    assign o_out_item = r_out;
    assign o_q_rd     = (r_state == S_IDLE) & ~i_q_empty;

    assign w_age1     = r_down_age + 32'd1;
    assign w_held_new = (r_ent.keys != r_down_set) ? 32'd0 : r_held + 32'd1;
    // a zero period behaves as one
    assign w_period   = (i_cfg.repeat_period_ms == 16'd0) ? 16'd1 : i_cfg.repeat_period_ms;
    assign w_trial    = {r_rem, r_dvd[31]};
    assign w_diff     = w_trial - {1'b0, w_period};

    always_comb begin
        n_state     = r_state;
        n_ent       = r_ent;
        n_tc        = r_tc;
        n_down_age  = r_down_age;
        n_held      = r_held;
        n_pressed   = r_pressed;
        n_down_set  = r_down_set;
        n_beep_rem  = r_beep_rem;
        n_beep_vol  = r_beep_vol;
        n_res_bits  = r_res_bits;
        n_res_held  = r_res_held;
        n_rep_keys  = r_rep_keys;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~pop;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_ent   = i_q_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_bits = 16'h0;
                n_res_held = 32'h0;
                n_state    = S_EMIT;
                unique case (r_ent.op)
                    kdar_pkg::OP_TICK: begin
                        n_tc = r_tc + 32'd1;
                        if (r_ent.keys != 16'h0) begin
                            if (w_age1 > {16'h0, i_cfg.debounce_ms}) begin
                                n_pressed = r_pressed | r_ent.keys;
                            end
                            n_down_age = 32'd0;
                        end else begin
                            n_down_age = w_age1;
                        end
                        n_down_set = r_ent.keys;
                        n_held     = w_held_new;
                        n_rep_keys = r_ent.keys & i_cfg.repeat_key_mask;
                        if (w_held_new > {16'h0, i_cfg.repeat_delay_ms} &&
                            (r_ent.keys & i_cfg.repeat_key_mask) != 16'h0) begin
                            n_state = S_LOAD;
                        end
                        if (r_beep_rem != 16'd0) begin
                            n_beep_rem = r_beep_rem - 16'd1;
                            if (r_beep_rem == 16'd1) n_beep_vol = 8'd0;
                        end
                    end
                    kdar_pkg::OP_PEEK: begin
                        n_res_bits = r_pressed & r_ent.sel;
                    end
                    kdar_pkg::OP_READ_CLR: begin
                        n_res_bits = r_pressed & r_ent.sel;
                        n_pressed  = r_pressed & ~r_ent.sel;
                    end
                    kdar_pkg::OP_HELD: begin
                        n_res_bits = r_down_set & r_ent.sel;
                        n_res_held = r_held;
                    end
                    kdar_pkg::OP_BEEP: begin
                        n_beep_vol = r_ent.beep_level;
                        n_beep_rem = r_ent.beep_ms;
                    end
                    kdar_pkg::OP_NOP: ;
                    default: ;
                endcase
            end
            S_LOAD: begin
                n_dvd   = r_held - {16'h0, i_cfg.repeat_delay_ms};
                n_rem   = 16'h0;
                n_cnt   = 5'd0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // restoring remainder, one dividend bit per cycle
                n_rem = w_diff[16] ? w_trial[15:0] : w_diff[15:0];
                n_dvd = {r_dvd[30:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) n_state = S_FIN;
            end
            S_FIN: begin
                if (r_rem == 16'h0) n_pressed = r_pressed | r_rep_keys;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || pop) begin
                    n_out.key_bits        = r_res_bits;
                    n_out.held_ticks      = r_res_held;
                    n_out.tick_now        = r_tc;
                    n_out.beep_volume_out = r_beep_vol;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_state     <= n_state;
        r_ent       <= n_ent;
        r_tc        <= n_tc;
        r_down_age  <= n_down_age;
        r_held      <= n_held;
        r_pressed   <= n_pressed;
        r_down_set  <= n_down_set;
        r_beep_rem  <= n_beep_rem;
        r_beep_vol  <= n_beep_vol;
        r_res_bits  <= n_res_bits;
        r_res_held  <= n_res_held;
        r_rep_keys  <= n_rep_keys;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_out       <= n_out;
        r_out_valid <= n_out_valid;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tc        <= 32'd0;
            r_down_age  <= 32'd0;
            r_held      <= 32'd0;
            r_pressed   <= 16'h0;
            r_down_set  <= 16'h0;
            r_beep_rem  <= 16'd0;
            r_beep_vol  <= 8'd0;
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/key_debounce_autorepeat_top.sv =====
// Top level of the key debounce / auto-repeat scanner.
// Depends on kdar_pkg, kdar_cfg, kdar_front, kdar_fifo and kdar_back.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------
//   input     push / full          i_in_item  (kdar_pkg::t_in_item)
//   result    pop / empty          o_out_item (kdar_pkg::t_out_item)
//   config    psel/penable/pready  paddr, pwdata, prdata (5 x 16-bit regs)
//
// Each command runs idle, execute and emit in the back end; a tick whose
// repeat key is past its delay also runs load, the 32-step serial
// remainder of held time less delay over the repeat period, and finish.
// A two-entry queue and the result register let input flow while a result
// waits. Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none

module key_debounce_autorepeat_top #(
    parameter int NUM_KEYS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire kdar_pkg::t_in_item   i_in_item,
    output logic                      empty,
    input  wire logic                 pop,
    output kdar_pkg::t_out_item       o_out_item,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    kdar_pkg::t_cfg       w_cfg;
    kdar_pkg::t_cmd_entry w_wr_entry;
    kdar_pkg::t_cmd_entry w_rd_entry;
    logic                 w_q_wr;
    logic                 w_q_full;
    logic                 w_q_rd;
    logic                 w_q_empty;

    kdar_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kdar_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_cfg     (w_cfg),
        .i_q_full  (w_q_full),
        .o_q_wr    (w_q_wr),
        .o_q_entry (w_wr_entry)
    );

    kdar_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_wr_entry),
        .o_full    (w_q_full),
        .i_rd      (w_q_rd),
        .o_empty   (w_q_empty),
        .o_rd_data (w_rd_entry)
    );

    kdar_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_rd_entry),
        .o_q_rd     (w_q_rd),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire
